// File: rtl/ccs_pkg.sv
// shared types and constants for the cursor follow camera scroller
// used by ccs_axis, ccs_core and the top level; no dependencies
`default_nettype none

package ccs_pkg;

  localparam int unsigned OUT_BITS    = 12;
  localparam int unsigned TILE_BITS   = 7;
  localparam int unsigned STEP_BITS   = 5;
  localparam int unsigned MARGIN_BITS = 8;
  localparam int unsigned MAX_BITS    = 11;
  localparam int unsigned RES_BITS    = 4;
  localparam int unsigned VEL_BITS    = 6;
  localparam int unsigned CFG_A_BITS  = 3;

  localparam logic [MARGIN_BITS-1:0] RST_MARGIN_LEFT   = 8'd32;
  localparam logic [MARGIN_BITS-1:0] RST_MARGIN_RIGHT  = 8'd192;
  localparam logic [MARGIN_BITS-1:0] RST_MARGIN_TOP    = 8'd32;
  localparam logic [MARGIN_BITS-1:0] RST_MARGIN_BOTTOM = 8'd112;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_PLACE    = 2'd1,
    CMD_RETARGET = 2'd2
  } cmd_e;

  typedef enum logic [CFG_A_BITS-1:0] {
    CFG_MARGIN_LEFT   = 3'd0,
    CFG_MARGIN_RIGHT  = 3'd1,
    CFG_MARGIN_TOP    = 3'd2,
    CFG_MARGIN_BOTTOM = 3'd3,
    CFG_CAMERA_MAX_X  = 3'd4,
    CFG_CAMERA_MAX_Y  = 3'd5
  } cfg_idx_e;

  // per-axis scroll motion: residue toward the 16-pixel grid and last velocity
  typedef struct packed {
    logic [RES_BITS-1:0] res;
    logic [VEL_BITS-1:0] vel;
  } motion_t;

  typedef struct packed {
    logic [MARGIN_BITS-1:0] margin_left;
    logic [MARGIN_BITS-1:0] margin_right;
    logic [MARGIN_BITS-1:0] margin_top;
    logic [MARGIN_BITS-1:0] margin_bottom;
    logic [MAX_BITS-1:0]    camera_max_x;
    logic [MAX_BITS-1:0]    camera_max_y;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/ccs_axis.sv
// one axis of a frame tick: sprite step toward target, dead-zone follow
// with clamp, and grid finish; depends on ccs_pkg
`default_nettype none

module ccs_axis #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0]             spr_i,
  input  wire logic [COORD_BITS-1:0]             tgt_i,
  input  wire logic [COORD_BITS-1:0]             cam_i,
  input  wire logic [ccs_pkg::MARGIN_BITS-1:0]   lo_i,
  input  wire logic [ccs_pkg::MARGIN_BITS-1:0]   hi_i,
  input  wire logic [ccs_pkg::MAX_BITS-1:0]      max_i,
  input  wire logic [ccs_pkg::STEP_BITS-1:0]     step_i,
  input  wire ccs_pkg::motion_t                  mot_i,
  input  wire logic                              fin_i,
  output logic      [COORD_BITS-1:0]             spr_o,
  output logic      [COORD_BITS-1:0]             cam_o,
  output ccs_pkg::motion_t                       mot_o,
  output logic                                   moved_o
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned E = COORD_BITS + 2;

  logic signed [W-1:0] spr_s, tgt_s, cam_s, s1_s, s2_s, c1_s, c2_s;
  logic signed [E-1:0] stp_e, lo_e, hi_e, max_e, t_e, s0_e, s1_e, sp_e, c0_e, c1_e, c2_e, v_e;
  logic signed [ccs_pkg::VEL_BITS-1:0] vel_s;
  logic [W-1:0] s1, s2, c1, c2;
  logic mv1, mv2;
  ccs_pkg::motion_t m1, m2;

  assign spr_s = spr_i;
  assign tgt_s = tgt_i;
  assign cam_s = cam_i;
  assign stp_e = signed'(E'(step_i));
  assign lo_e  = signed'(E'(lo_i));
  assign hi_e  = signed'(E'(hi_i));
  assign max_e = signed'(E'(max_i));
  assign t_e   = E'(tgt_s);
  assign s0_e  = E'(spr_s);
  assign c0_e  = E'(cam_s);

  // sprite: step up toward target, then step down, second check sees the first
  assign s1   = (s0_e < t_e) ? W'(s0_e + stp_e) : spr_i;
  assign s1_s = s1;
  assign s1_e = E'(s1_s);
  assign s2   = (s1_e > t_e) ? W'(s1_e - stp_e) : s1;
  assign s2_s = s2;
  assign sp_e = E'(s2_s);

  // low edge of the dead zone
  always_comb begin
    c1  = cam_i;
    mv1 = 1'b0;
    m1  = mot_i;
    if (c0_e + lo_e > sp_e) begin
      if (sp_e - lo_e < 0) begin
        c1 = '0;
      end else begin
        mv1    = 1'b1;
        c1     = W'(c0_e - stp_e);
        m1.vel = ccs_pkg::VEL_BITS'(-stp_e);
        m1.res = c1[ccs_pkg::RES_BITS-1:0];
      end
    end
  end

  assign c1_s = c1;
  assign c1_e = E'(c1_s);

  // high edge of the dead zone
  always_comb begin
    c2  = c1;
    mv2 = 1'b0;
    m2  = m1;
    if (c1_e + hi_e < sp_e) begin
      if (sp_e - hi_e > max_e) begin
        c2 = W'(max_i);
      end else begin
        mv2    = 1'b1;
        c2     = W'(c1_e + stp_e);
        m2.vel = ccs_pkg::VEL_BITS'(stp_e);
        m2.res = c2[ccs_pkg::RES_BITS-1:0];
      end
    end
  end

  assign c2_s  = c2;
  assign c2_e  = E'(c2_s);
  assign vel_s = m2.vel;
  assign v_e   = E'(vel_s);

  // grid finish with the last velocity
  always_comb begin
    cam_o = c2;
    mot_o = m2;
    if (fin_i && (m2.res != '0)) begin
      mot_o.res = m2.res + m2.vel[ccs_pkg::RES_BITS-1:0];
      cam_o     = W'(c2_e + v_e);
    end
  end

  assign spr_o   = s2;
  assign moved_o = mv1 | mv2;

endmodule

`default_nettype wire

// File: rtl/ccs_core.sv
// scroller state registers and per-command next-state logic
// depends on ccs_pkg and ccs_axis
`default_nettype none

module ccs_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire ccs_pkg::cmd_e                   cmd_i,
  input  wire logic [ccs_pkg::TILE_BITS-1:0]   tile_x_i,
  input  wire logic [ccs_pkg::TILE_BITS-1:0]   tile_y_i,
  input  wire logic [ccs_pkg::STEP_BITS-1:0]   step_i,
  input  wire ccs_pkg::cfg_t                   cfg_i,
  output logic      [COORD_BITS-1:0]           cam_x_o,
  output logic      [COORD_BITS-1:0]           cam_y_o,
  output logic      [COORD_BITS-1:0]           spr_x_o,
  output logic      [COORD_BITS-1:0]           spr_y_o,
  output logic                                 scrolled_o
);

  localparam int unsigned W = COORD_BITS;

  logic [W-1:0] cam_x_q, cam_y_q, spr_x_q, spr_y_q, tgt_x_q, tgt_y_q;
  logic [W-1:0] cam_x_d, cam_y_d, spr_x_d, spr_y_d, tgt_x_d, tgt_y_d;
  ccs_pkg::motion_t mot_x_q, mot_y_q, mot_x_d, mot_y_d;

  logic [W-1:0] tile_px_x, tile_px_y;
  logic [W-1:0] ax_spr_x, ax_spr_y, ax_cam_x, ax_cam_y;
  ccs_pkg::motion_t ax_mot_x, ax_mot_y;
  logic mv_x, mv_y, fin;

  assign tile_px_x = W'({tile_x_i, 4'h0});
  assign tile_px_y = W'({tile_y_i, 4'h0});
  assign fin       = ~(mv_x | mv_y);

  ccs_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .spr_i   (spr_x_q),
    .tgt_i   (tgt_x_q),
    .cam_i   (cam_x_q),
    .lo_i    (cfg_i.margin_left),
    .hi_i    (cfg_i.margin_right),
    .max_i   (cfg_i.camera_max_x),
    .step_i  (step_i),
    .mot_i   (mot_x_q),
    .fin_i   (fin),
    .spr_o   (ax_spr_x),
    .cam_o   (ax_cam_x),
    .mot_o   (ax_mot_x),
    .moved_o (mv_x)
  );

  ccs_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .spr_i   (spr_y_q),
    .tgt_i   (tgt_y_q),
    .cam_i   (cam_y_q),
    .lo_i    (cfg_i.margin_top),
    .hi_i    (cfg_i.margin_bottom),
    .max_i   (cfg_i.camera_max_y),
    .step_i  (step_i),
    .mot_i   (mot_y_q),
    .fin_i   (fin),
    .spr_o   (ax_spr_y),
    .cam_o   (ax_cam_y),
    .mot_o   (ax_mot_y),
    .moved_o (mv_y)
  );

  always_comb begin
    cam_x_d    = cam_x_q;
    cam_y_d    = cam_y_q;
    spr_x_d    = spr_x_q;
    spr_y_d    = spr_y_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    mot_x_d    = mot_x_q;
    mot_y_d    = mot_y_q;
    scrolled_o = 1'b0;
    unique case (cmd_i)
      ccs_pkg::CMD_PLACE: begin
        spr_x_d = tile_px_x;
        spr_y_d = tile_px_y;
        tgt_x_d = tile_px_x;
        tgt_y_d = tile_px_y;
      end
      ccs_pkg::CMD_RETARGET: begin
        tgt_x_d = tile_px_x;
        tgt_y_d = tile_px_y;
      end
      ccs_pkg::CMD_TICK: begin
        spr_x_d    = ax_spr_x;
        spr_y_d    = ax_spr_y;
        cam_x_d    = ax_cam_x;
        cam_y_d    = ax_cam_y;
        mot_x_d    = ax_mot_x;
        mot_y_d    = ax_mot_y;
        scrolled_o = mv_x | mv_y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      spr_x_q <= '0;
      spr_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      mot_x_q <= '0;
      mot_y_q <= '0;
    end else if (en_i) begin
      cam_x_q <= cam_x_d;
      cam_y_q <= cam_y_d;
      spr_x_q <= spr_x_d;
      spr_y_q <= spr_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      mot_x_q <= mot_x_d;
      mot_y_q <= mot_y_d;
    end
  end

  assign cam_x_o = cam_x_d;
  assign cam_y_o = cam_y_d;
  assign spr_x_o = spr_x_d;
  assign spr_y_o = spr_y_d;

endmodule

`default_nettype wire

// File: rtl/cursor_follow_camera_scroller.sv
// cursor follow camera scroller, top level: input word register, config
// registers, ccs_core and result register; depends on ccs_pkg and ccs_core
// an accepted word waits in the input word register; when the result register
//   is free it is processed into the result register and offered on m_axis
// throughput: one word per cycle while m_axis_tready keeps the result register free
// reset: positions, targets and motion clear to zero, margins to 32/192/32/112,
//   camera maxima to zero; no clearing pass
`default_nettype none

module cursor_follow_camera_scroller #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [23:0]                        s_axis_tdata,  // tile_x, tile_y, step
  input  wire logic [1:0]                         s_axis_tuser,  // cmd
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // camera_x, camera_y, sprite_x, sprite_y, scrolled
  output logic      [55:0]                        m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [ccs_pkg::CFG_A_BITS-1:0]     cfg_addr_i,
  input  wire logic [ccs_pkg::MAX_BITS-1:0]       cfg_wdata_i
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned OB = ccs_pkg::OUT_BITS;

  logic in_valid_q, out_valid_q;
  logic out_free, proc;
  ccs_pkg::cmd_e in_cmd_q;
  logic [ccs_pkg::TILE_BITS-1:0] in_tile_x_q, in_tile_y_q;
  logic [ccs_pkg::STEP_BITS-1:0] in_step_q;
  ccs_pkg::cfg_t cfg_q;

  logic [W-1:0] cam_x, cam_y, spr_x, spr_y;
  logic scrolled;
  logic [OB-1:0] out_cam_x_q, out_cam_y_q, out_spr_x_q, out_spr_y_q;
  logic out_scrolled_q;

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign proc          = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q    <= ccs_pkg::cmd_e'(s_axis_tuser);
      in_tile_x_q <= s_axis_tdata[6:0];
      in_tile_y_q <= s_axis_tdata[13:7];
      in_step_q   <= s_axis_tdata[18:14];
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin_left   <= ccs_pkg::RST_MARGIN_LEFT;
      cfg_q.margin_right  <= ccs_pkg::RST_MARGIN_RIGHT;
      cfg_q.margin_top    <= ccs_pkg::RST_MARGIN_TOP;
      cfg_q.margin_bottom <= ccs_pkg::RST_MARGIN_BOTTOM;
      cfg_q.camera_max_x  <= '0;
      cfg_q.camera_max_y  <= '0;
    end else if (cfg_we_i) begin
      unique case (ccs_pkg::cfg_idx_e'(cfg_addr_i))
        ccs_pkg::CFG_MARGIN_LEFT:   cfg_q.margin_left   <= cfg_wdata_i[7:0];
        ccs_pkg::CFG_MARGIN_RIGHT:  cfg_q.margin_right  <= cfg_wdata_i[7:0];
        ccs_pkg::CFG_MARGIN_TOP:    cfg_q.margin_top    <= cfg_wdata_i[7:0];
        ccs_pkg::CFG_MARGIN_BOTTOM: cfg_q.margin_bottom <= cfg_wdata_i[7:0];
        ccs_pkg::CFG_CAMERA_MAX_X:  cfg_q.camera_max_x  <= cfg_wdata_i;
        ccs_pkg::CFG_CAMERA_MAX_Y:  cfg_q.camera_max_y  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ccs_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (proc),
    .cmd_i      (in_cmd_q),
    .tile_x_i   (in_tile_x_q),
    .tile_y_i   (in_tile_y_q),
    .step_i     (in_step_q),
    .cfg_i      (cfg_q),
    .cam_x_o    (cam_x),
    .cam_y_o    (cam_y),
    .spr_x_o    (spr_x),
    .spr_y_o    (spr_y),
    .scrolled_o (scrolled)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_cam_x_q    <= OB'(cam_x);
      out_cam_y_q    <= OB'(cam_y);
      out_spr_x_q    <= OB'(spr_x);
      out_spr_y_q    <= OB'(spr_y);
      out_scrolled_q <= scrolled;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'h00, out_scrolled_q, out_spr_y_q, out_spr_x_q,
                          out_cam_y_q, out_cam_x_q};

  a_no_scroll_on_non_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (in_cmd_q != ccs_pkg::CMD_TICK) |=> !out_scrolled_q)
    else $error("scroll flag set for a command that is not a tick");

  a_place_sets_sprite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (in_cmd_q == ccs_pkg::CMD_PLACE) |=>
      (out_spr_x_q == OB'(W'({$past(in_tile_x_q), 4'h0}))) &&
      (out_spr_y_q == OB'(W'({$past(in_tile_y_q), 4'h0}))))
    else $error("place command did not put the sprite on the tile");

  a_retarget_keeps_camera: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (in_cmd_q == ccs_pkg::CMD_RETARGET) |=>
      (out_cam_x_q == OB'($past(cam_x))) && (out_cam_y_q == OB'($past(cam_y))))
    else $error("retarget command moved the camera");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled while a stage was free");

endmodule

`default_nettype wire

// File: tb/cursor_follow_camera_scroller_chk.sv
`timescale 1ns / 100ps
// checker for cursor_follow_camera_scroller: mirrors the config writes, predicts
// the camera and sprite view after every command word and compares result words
// depends on ccs_pkg for the command and register codes and the config layout

module cursor_follow_camera_scroller_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // tile_x, tile_y, step
  input  logic [1:0]                     s_axis_tuser,  // cmd
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // camera_x, camera_y, sprite_x, sprite_y, scrolled
  input  logic [55:0]                    m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [ccs_pkg::CFG_A_BITS-1:0] cfg_addr_i,
  input  logic [ccs_pkg::MAX_BITS-1:0]   cfg_wdata_i,
  output int                             fail_cnt_o,
  output int                             pending_o
);

  localparam int W = ccs_pkg::OUT_BITS;

  typedef struct packed {
    logic [6:0]   pad;
    logic         scrolled;
    logic [W-1:0] sprite_y;
    logic [W-1:0] sprite_x;
    logic [W-1:0] camera_y;
    logic [W-1:0] camera_x;
  } view_t;

  typedef struct packed {
    logic [W-1:0]                  cam;
    logic [ccs_pkg::RES_BITS-1:0]  res;
    logic [ccs_pkg::VEL_BITS-1:0]  vel;
    logic                          moved;
  } axis_t;

  ccs_pkg::cfg_t cfg;
  axis_t         ax, ay;
  logic [W-1:0]  spr_x, spr_y, tgt_x, tgt_y;
  view_t         views[$];

  function automatic int sext(logic [W-1:0] v);
    return int'(signed'(v));
  endfunction

  // sprite walks toward its target; the second compare sees the first move
  function automatic logic [W-1:0] chase(logic [W-1:0] s, logic [W-1:0] t, int st);
    if (sext(s) < sext(t)) s = W'(sext(s) + st);
    if (sext(s) > sext(t)) s = W'(sext(s) - st);
    return s;
  endfunction

  // dead zone follow for one axis, clamps do not count as a scroll
  function automatic axis_t track(axis_t a, int spr, int lo, int hi, int lim, int st);
    a.moved = 1'b0;
    if (sext(a.cam) + lo > spr) begin
      if (spr - lo < 0) begin
        a.cam = '0;
      end else begin
        a.moved = 1'b1;
        a.cam   = W'(sext(a.cam) - st);
        a.vel   = ccs_pkg::VEL_BITS'(-st);
        a.res   = a.cam[3:0];
      end
    end
    if (sext(a.cam) + hi < spr) begin
      if (spr - hi > lim) begin
        a.cam = W'(lim);
      end else begin
        a.moved = 1'b1;
        a.cam   = W'(sext(a.cam) + st);
        a.vel   = ccs_pkg::VEL_BITS'(st);
        a.res   = a.cam[3:0];
      end
    end
    return a;
  endfunction

  // glide on to the 16 pixel grid with the last velocity
  function automatic axis_t settle(axis_t a);
    if (a.res != '0) begin
      a.res = a.res + a.vel[3:0];
      a.cam = W'(sext(a.cam) + int'(signed'(a.vel)));
    end
    return a;
  endfunction

  task automatic advance(input logic [1:0] code, input logic [23:0] word);
    logic [6:0] tx, ty;
    int         st;
    view_t      v;
    tx = word[6:0];
    ty = word[13:7];
    st = int'(word[18:14]);
    v  = '0;
    case (code)
      ccs_pkg::CMD_PLACE: begin
        spr_x = W'({tx, 4'b0});
        spr_y = W'({ty, 4'b0});
        tgt_x = spr_x;
        tgt_y = spr_y;
      end
      ccs_pkg::CMD_RETARGET: begin
        tgt_x = W'({tx, 4'b0});
        tgt_y = W'({ty, 4'b0});
      end
      ccs_pkg::CMD_TICK: begin
        spr_x = chase(spr_x, tgt_x, st);
        spr_y = chase(spr_y, tgt_y, st);
        ax = track(ax, sext(spr_x), int'(cfg.margin_left), int'(cfg.margin_right),
                   int'(cfg.camera_max_x), st);
        ay = track(ay, sext(spr_y), int'(cfg.margin_top), int'(cfg.margin_bottom),
                   int'(cfg.camera_max_y), st);
        v.scrolled = ax.moved | ay.moved;
        if (!v.scrolled) begin
          ax = settle(ax);
          ay = settle(ay);
        end
      end
      default: ;
    endcase
    v.camera_x = ax.cam;
    v.camera_y = ay.cam;
    v.sprite_x = spr_x;
    v.sprite_y = spr_y;
    views.push_back(v);
  endtask

  task automatic report(input string what, input int got, input int want);
    if (fail_cnt_o < 40)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i) begin
    view_t got, want;
    if (!rst_ni) begin
      cfg.margin_left   = ccs_pkg::RST_MARGIN_LEFT;
      cfg.margin_right  = ccs_pkg::RST_MARGIN_RIGHT;
      cfg.margin_top    = ccs_pkg::RST_MARGIN_TOP;
      cfg.margin_bottom = ccs_pkg::RST_MARGIN_BOTTOM;
      cfg.camera_max_x  = '0;
      cfg.camera_max_y  = '0;
      ax = '0;
      ay = '0;
      spr_x = '0;
      spr_y = '0;
      tgt_x = '0;
      tgt_y = '0;
      views.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ccs_pkg::CFG_MARGIN_LEFT:   cfg.margin_left   = cfg_wdata_i[7:0];
          ccs_pkg::CFG_MARGIN_RIGHT:  cfg.margin_right  = cfg_wdata_i[7:0];
          ccs_pkg::CFG_MARGIN_TOP:    cfg.margin_top    = cfg_wdata_i[7:0];
          ccs_pkg::CFG_MARGIN_BOTTOM: cfg.margin_bottom = cfg_wdata_i[7:0];
          ccs_pkg::CFG_CAMERA_MAX_X:  cfg.camera_max_x  = cfg_wdata_i;
          ccs_pkg::CFG_CAMERA_MAX_Y:  cfg.camera_max_y  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) advance(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (views.size() == 0) begin
          report("word with nothing pending", int'(got.camera_x), 0);
        end else begin
          want = views.pop_front();
          if (got.camera_x !== want.camera_x)
            report("camera_x", int'(got.camera_x), int'(want.camera_x));
          if (got.camera_y !== want.camera_y)
            report("camera_y", int'(got.camera_y), int'(want.camera_y));
          if (got.sprite_x !== want.sprite_x)
            report("sprite_x", int'(got.sprite_x), int'(want.sprite_x));
          if (got.sprite_y !== want.sprite_y)
            report("sprite_y", int'(got.sprite_y), int'(want.sprite_y));
          if (got.scrolled !== want.scrolled)
            report("scrolled", int'(got.scrolled), int'(want.scrolled));
          if (got.pad !== want.pad)
            report("padding", int'(got.pad), int'(want.pad));
        end
      end
    end
    pending_o = views.size();
  end

endmodule

// File: tb/cursor_follow_camera_scroller_tb.sv
`timescale 1ns / 100ps
// testbench top for cursor_follow_camera_scroller: clock, reset, config phases,
// command words with bursty sender and stalling receiver, and the verdict
// depends on ccs_pkg, the block and cursor_follow_camera_scroller_chk

module cursor_follow_camera_scroller_tb;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 400;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [23:0]                    s_axis_tdata;   // tile_x, tile_y, step
  logic [1:0]                     s_axis_tuser;   // cmd
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  // camera_x, camera_y, sprite_x, sprite_y, scrolled
  logic [55:0]                    m_axis_tdata;
  logic                           cfg_we;
  logic [ccs_pkg::CFG_A_BITS-1:0] cfg_addr;
  logic [ccs_pkg::MAX_BITS-1:0]   cfg_wdata;

  int         fail_cnt;
  int         pending;
  int         cycle_cnt;
  int         burst_left;
  bit         tx_idle_en;
  bit         hold_req;
  bit         hold_done;
  logic [6:0] cur_tx, cur_ty;

  cursor_follow_camera_scroller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  cursor_follow_camera_scroller_chk chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: ready and stall runs of random length, one long hold on request
  initial begin
    int run;
    bit rx_on;
    bit rx_busy;
    m_axis_tready = 1'b0;
    run = 0;
    rx_on = 1'b0;
    rx_busy = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
        run = 0;
      end
      if (run == 0) begin
        if ($urandom_range(0, 30) == 0) rx_busy = !rx_busy;
        rx_on = !rx_on || !rx_busy;
        run = rx_on ? $urandom_range(1, 16) : $urandom_range(1, 6);
      end
      run--;
      m_axis_tready <= rx_on;
    end
  end

  task automatic send_item(input logic [1:0] code, input logic [6:0] tx,
                           input logic [6:0] ty, input logic [4:0] st);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_idle_en ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= {5'b0, st, ty, tx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender stops until every result is back, then lets the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_put(input ccs_pkg::cfg_idx_e idx, input int val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= ccs_pkg::MAX_BITS'(val);
    @(negedge clk_i);
  endtask

  task automatic cfg_load(input int ml, input int mr, input int mt, input int mb,
                          input int mx, input int my);
    cfg_put(ccs_pkg::CFG_MARGIN_LEFT, ml);
    cfg_put(ccs_pkg::CFG_MARGIN_RIGHT, mr);
    cfg_put(ccs_pkg::CFG_MARGIN_TOP, mt);
    cfg_put(ccs_pkg::CFG_MARGIN_BOTTOM, mb);
    cfg_put(ccs_pkg::CFG_CAMERA_MAX_X, mx);
    cfg_put(ccs_pkg::CFG_CAMERA_MAX_Y, my);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [6:0] near_tile(input logic [6:0] c);
    int t;
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    t = int'(c) + $urandom_range(0, 40) - 20;
    if (t < 0) t = 0;
    if (t > 127) t = 127;
    return 7'(t);
  endfunction

  // cursor walks: optional place, retarget nearby, a run of ticks; some noise
  task automatic run_random(input int n_items);
    int         done_cnt;
    int         ticks;
    logic [4:0] st;
    logic [1:0] code;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        code = 2'($urandom_range(0, 3));
        send_item(code, 7'($urandom), 7'($urandom), 5'($urandom));
        if (code != CMD_UNUSED) done_cnt++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          cur_tx = near_tile(cur_tx);
          cur_ty = near_tile(cur_ty);
          send_item(ccs_pkg::CMD_PLACE, cur_tx, cur_ty, 5'($urandom));
          done_cnt++;
        end
        cur_tx = near_tile(cur_tx);
        cur_ty = near_tile(cur_ty);
        send_item(ccs_pkg::CMD_RETARGET, cur_tx, cur_ty, 5'($urandom));
        done_cnt++;
        st = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'(1 << $urandom_range(0, 4));
        ticks = $urandom_range(3, 40);
        repeat (ticks) begin
          send_item(ccs_pkg::CMD_TICK, 7'($urandom), 7'($urandom), st);
          done_cnt++;
        end
        if ($urandom_range(0, 15) == 0) drain();
      end
    end
    drain();
  endtask

  initial begin
    int ml;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    cycle_cnt     = 0;
    burst_left    = 0;
    tx_idle_en    = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    cur_tx        = '0;
    cur_ty        = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every command, overshoot, clamps, grid settle
    cfg_load(32, 192, 32, 112, 1024, 768);
    send_item(CMD_UNUSED, 7'd127, 7'd127, 5'd31);
    send_item(ccs_pkg::CMD_PLACE, 7'd0, 7'd0, 5'd0);
    send_item(ccs_pkg::CMD_TICK, 7'd0, 7'd0, 5'd0);
    send_item(ccs_pkg::CMD_RETARGET, 7'd127, 7'd127, 5'd16);
    repeat (8) send_item(ccs_pkg::CMD_TICK, 7'd0, 7'd0, 5'd16);
    send_item(ccs_pkg::CMD_PLACE, 7'd127, 7'd127, 5'd0);
    send_item(ccs_pkg::CMD_TICK, 7'd127, 7'd127, 5'd1);
    send_item(ccs_pkg::CMD_RETARGET, 7'd0, 7'd0, 5'd0);
    send_item(ccs_pkg::CMD_TICK, 7'd0, 7'd0, 5'd31);
    send_item(ccs_pkg::CMD_TICK, 7'd0, 7'd0, 5'd31);
    send_item(ccs_pkg::CMD_PLACE, 7'd3, 7'd2, 5'd0);
    send_item(ccs_pkg::CMD_RETARGET, 7'd5, 7'd2, 5'd0);
    repeat (3) send_item(ccs_pkg::CMD_TICK, 7'd0, 7'd0, 5'd5);
    send_item(ccs_pkg::CMD_TICK, 7'd0, 7'd0, 5'd0);
    send_item(ccs_pkg::CMD_RETARGET, 7'd0, 7'd0, 5'd0);
    drain();

    // random phases, each under its own register setting
    cfg_load(0, 0, 0, 0, 2047, 2047);
    run_random(205);
    cfg_load(255, 255, 255, 255, 0, 0);
    run_random(205);
    ml = $urandom_range(0, 120);
    cfg_load(ml, $urandom_range(ml, 255), $urandom_range(0, 60), $urandom_range(60, 200),
             $urandom_range(200, 1600), $urandom_range(200, 1600));
    hold_req = 1'b1;
    run_random(205);
    cfg_load(32, 192, 32, 112, 600, 400);
    run_random(205);
    cfg_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 2047), $urandom_range(0, 2047));
    run_random(205);

    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
